/* hw/rtl/hfla_pkg.sv */
// ----------------------------------------------------------------------------
// hfla_pkg
// Shared types and constants of the handle free-list allocator.
// ----------------------------------------------------------------------------
package hfla_pkg;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 8;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 9;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC          = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE           = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE_LOWEST = 2'd2;

	// flags are summarized in groups of this many for the lowest-entry search
	localparam int GROUP_LOG2 = 4;
	localparam int GROUP_SIZE = 1 << GROUP_LOG2;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [WORD_W-1:0]   payload_in;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [HANDLE_W-1:0] handle_out;
		logic [WORD_W-1:0]   payload_out;
		logic [COUNT_W-1:0]  used_count;
	} rsp_t;

	typedef struct packed {
		logic clear_all;
		logic set_en;
		logic clr_en;
		logic grp_en;
	} flag_ctl_t;

endpackage

/* hw/rtl/hfla_if.sv */
// ----------------------------------------------------------------------------
// hfla_if
// Valid/ready channels of the allocator: request, response and count write.
// ----------------------------------------------------------------------------
interface hfla_req_if;
	logic              valid;
	logic              ready;
	hfla_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hfla_rsp_if;
	logic              valid;
	logic              ready;
	hfla_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hfla_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hfla_pkg::COUNT_W-1:0]     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hfla_ram.sv */
// ----------------------------------------------------------------------------
// hfla_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfla_ram #(
	parameter int  DEPTH = 256,
	parameter int  WIDTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/hfla_flags.sv */
// ----------------------------------------------------------------------------
// hfla_flags
// In-use flags with a registered group summary and a two-step search for
// the lowest in-use handle.
// ----------------------------------------------------------------------------
module hfla_flags #(
	parameter int  MAX_HANDLES = 256,
	localparam int HW          = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1,
	localparam int GROUPS      = (MAX_HANDLES + hfla_pkg::GROUP_SIZE - 1) / hfla_pkg::GROUP_SIZE,
	localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hfla_pkg::flag_ctl_t ctl,
	input  logic [HW-1:0]       idx,
	input  logic [HW-1:0]       query,
	output logic                hit,
	output logic [HW-1:0]       lowest
);

	logic [MAX_HANDLES-1:0]                   flags_q;
	logic [GROUPS*hfla_pkg::GROUP_SIZE-1:0]   flags_pad;
	logic [GROUPS-1:0]                        group_any_q;
	logic [GW-1:0]                            grp_sel;
	logic [GW-1:0]                            grp_q;
	logic [hfla_pkg::GROUP_SIZE-1:0]          grp_bits;
	logic [hfla_pkg::GROUP_LOG2-1:0]          bit_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.clear_all) begin
			flags_q <= '0;
		end else begin
			if (ctl.set_en) begin
				flags_q[idx] <= 1'b1;
			end
			if (ctl.clr_en) begin
				flags_q[idx] <= 1'b0;
			end
		end
	end

	always_comb begin
		flags_pad = '0;
		flags_pad[MAX_HANDLES-1:0] = flags_q;
	end

	// group summary is a registered copy of the per-group OR of the flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_any_q <= '0;
		end else begin
			for (int k = 0; k < GROUPS; k++) begin
				group_any_q[k] <= |flags_pad[k*hfla_pkg::GROUP_SIZE +: hfla_pkg::GROUP_SIZE];
			end
		end
	end

	always_comb begin
		grp_sel = '0;
		for (int k = GROUPS - 1; k >= 0; k--) begin
			if (group_any_q[k]) begin
				grp_sel = GW'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (ctl.grp_en) begin
			grp_q <= grp_sel;
		end
	end

	always_comb begin
		grp_bits = flags_pad[grp_q*hfla_pkg::GROUP_SIZE +: hfla_pkg::GROUP_SIZE];
		bit_sel  = '0;
		for (int j = hfla_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
			if (grp_bits[j]) begin
				bit_sel = hfla_pkg::GROUP_LOG2'(j);
			end
		end
	end

	assign lowest = HW'({grp_q, bit_sel});
	assign hit    = flags_pad[query];

endmodule

/* hw/rtl/handle_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// handle_free_list_allocator
// Handle table with a LIFO free list threaded through per-entry links.
// ----------------------------------------------------------------------------
// Each request is alloc (pop the free head, store the payload, return the
// handle), free (check the handle is active and in use, return its payload,
// push it) or release-lowest (free the lowest in-use handle). One request is
// worked at a time: alloc and free read the link or payload RAM at the
// transfer; release-lowest first finds the lowest in-use handle in two
// registered steps (first group of 16 flags, then the bit inside it) and
// then reads the payload. A finished result waits in the output register
// while the next request is taken. Reset, and every write of the active
// count, rebuild the table at once: in-use flags clear together and handles
// never handed out since the rebuild take their links from a fill pointer,
// so no clearing pass is run and requests are accepted right away. A count
// of 0 acts as 1 and a count above MAX_HANDLES acts as MAX_HANDLES.
// ----------------------------------------------------------------------------
module handle_free_list_allocator #(
	parameter int MAX_HANDLES  = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hfla_req_if.sink   req,
	hfla_rsp_if.source rsp,
	hfla_cfg_if.sink   cfg
);

	localparam int HW      = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
	localparam int LW      = $clog2(MAX_HANDLES + 1);
	localparam int RESET_N = (MAX_HANDLES < 256) ? MAX_HANDLES : 256;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GRP  = 4'b0010,
		ST_PICK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                       st_q;
	logic [hfla_pkg::OP_W-1:0]    op_q;
	logic                         ok_q;
	logic [HW-1:0]                idx_q;
	logic [LW-1:0]                head_q;
	logic [LW-1:0]                count_q;
	logic [LW-1:0]                fresh_q;
	logic [LW-1:0]                n_q;
	logic                         out_valid_q;
	hfla_pkg::rsp_t               out_data_q;

	logic                         accept;
	logic                         cfg_fire;
	logic                         done_go;
	logic                         alloc_ok;
	logic                         free_ok;
	logic                         acc_ok;
	logic [HW-1:0]                head_idx;
	logic [HW-1:0]                req_idx;
	logic [LW-1:0]                cfg_n;
	logic                         is_fresh;
	logic [LW-1:0]                alloc_next;
	logic [LW-1:0]                count_next;

	logic                         pay_we;
	logic                         pay_re;
	logic [HW-1:0]                rel_addr;
	logic [PAYLOAD_BITS-1:0]      pay_rdata;
	logic                         link_re;
	logic                         link_we;
	logic [LW-1:0]                link_rdata;

	hfla_pkg::flag_ctl_t          flag_ctl;
	logic                         flag_hit;
	logic [HW-1:0]                lowest;

	assign accept   = req.valid && req.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign done_go  = (st_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready = (st_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready = (st_q == ST_IDLE);

	assign head_idx = HW'(head_q - LW'(1));
	assign req_idx  = HW'(req.data.handle_in);
	assign alloc_ok = (head_q != '0) && (head_q <= n_q);
	assign free_ok  = (32'(req.data.handle_in) < 32'(n_q)) && flag_hit;

	always_comb begin
		case (req.data.op)
			hfla_pkg::OP_ALLOC:          acc_ok = alloc_ok;
			hfla_pkg::OP_FREE:           acc_ok = free_ok;
			hfla_pkg::OP_RELEASE_LOWEST: acc_ok = (count_q != '0);
			default:                     acc_ok = 1'b0;
		endcase
	end

	always_comb begin
		if (cfg.data == '0) begin
			cfg_n = LW'(1);
		end else if (32'(cfg.data) > MAX_HANDLES) begin
			cfg_n = LW'(MAX_HANDLES);
		end else begin
			cfg_n = LW'(cfg.data);
		end
	end

	// handles at or above the fill pointer still carry their rebuild links
	always_comb begin
		is_fresh = (LW'(idx_q) >= fresh_q);
		if (is_fresh) begin
			alloc_next = ((LW'(idx_q) + LW'(1)) < n_q) ? (LW'(idx_q) + LW'(2)) : '0;
		end else begin
			alloc_next = link_rdata;
		end
	end

	always_comb begin
		if (!ok_q) begin
			count_next = count_q;
		end else if (op_q == hfla_pkg::OP_ALLOC) begin
			count_next = count_q + LW'(1);
		end else begin
			count_next = count_q - LW'(1);
		end
	end

	// memory accesses: alloc at the transfer, free at the transfer,
	// release-lowest once the search has settled
	assign pay_we   = accept && (req.data.op == hfla_pkg::OP_ALLOC) && alloc_ok;
	assign link_re  = pay_we;
	assign pay_re   = (accept && (req.data.op == hfla_pkg::OP_FREE) && free_ok)
			|| ((st_q == ST_PICK) && ok_q);
	assign link_we  = pay_re;
	assign rel_addr = accept ? req_idx : lowest;

	hfla_ram #(
		.DEPTH (MAX_HANDLES),
		.WIDTH (PAYLOAD_BITS)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (head_idx),
		.wdata (PAYLOAD_BITS'(req.data.payload_in)),
		.re    (pay_re),
		.raddr (rel_addr),
		.rdata (pay_rdata)
	);

	hfla_ram #(
		.DEPTH (MAX_HANDLES),
		.WIDTH (LW)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (rel_addr),
		.wdata (head_q),
		.re    (link_re),
		.raddr (head_idx),
		.rdata (link_rdata)
	);

	always_comb begin
		flag_ctl.clear_all = cfg_fire;
		flag_ctl.set_en    = done_go && ok_q && (op_q == hfla_pkg::OP_ALLOC);
		flag_ctl.clr_en    = done_go && ok_q && (op_q != hfla_pkg::OP_ALLOC);
		flag_ctl.grp_en    = (st_q == ST_GRP);
	end

	hfla_flags #(
		.MAX_HANDLES (MAX_HANDLES)
	) u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (flag_ctl),
		.idx    (idx_q),
		.query  (req_idx),
		.hit    (flag_hit),
		.lowest (lowest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			op_q  <= hfla_pkg::OP_ALLOC;
			ok_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= req.data.op;
						ok_q  <= acc_ok;
						idx_q <= (req.data.op == hfla_pkg::OP_ALLOC) ? head_idx : req_idx;
						if ((req.data.op == hfla_pkg::OP_RELEASE_LOWEST) && acc_ok) begin
							st_q <= ST_GRP;
						end else begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_GRP: begin
					st_q <= ST_PICK;
				end
				ST_PICK: begin
					idx_q <= lowest;
					st_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (done_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= LW'(1);
			count_q <= '0;
			fresh_q <= '0;
			n_q     <= LW'(RESET_N);
		end else if (cfg_fire) begin
			head_q  <= LW'(1);
			count_q <= '0;
			fresh_q <= '0;
			n_q     <= cfg_n;
		end else if (done_go && ok_q) begin
			count_q <= count_next;
			if (op_q == hfla_pkg::OP_ALLOC) begin
				head_q <= alloc_next;
				if (is_fresh) begin
					fresh_q <= LW'(idx_q) + LW'(1);
				end
			end else begin
				head_q <= LW'(idx_q) + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_data_q.ok          <= ok_q;
			out_data_q.handle_out  <= ok_q ? hfla_pkg::HANDLE_W'(idx_q) : '0;
			out_data_q.payload_out <= (ok_q && (op_q != hfla_pkg::OP_ALLOC))
					? hfla_pkg::WORD_W'(pay_rdata) : '0;
			out_data_q.used_count  <= hfla_pkg::COUNT_W'(count_next);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= n_q)
		else $error("in-use count above active entries");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= n_q)
		else $error("free head outside active range");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= n_q)
		else $error("fill pointer outside active range");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_DONE))
		else $error("result raised outside the completion state");

endmodule

/* tb/handle_free_list_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_free_list_allocator_tb
// Self-checking bench for the handle allocator. A queue of requests and
// count writes feeds a clocked driver. A shadow table is updated on every
// accepted request and predicts the response. A clocked monitor compares
// each response field by field. Both sides idle at random, and the response
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module handle_free_list_allocator_tb;

	localparam int MAX_HANDLES = 256;
	localparam logic [hfla_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
	// table copies: one steers stimulus generation, one predicts at transfer
	localparam int GEN = 0;
	localparam int CHK = 1;

	typedef struct packed {
		bit                           is_cfg;
		logic [hfla_pkg::COUNT_W-1:0] count;
		hfla_pkg::req_t               req;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	hfla_req_if req_ch ();
	hfla_rsp_if rsp_ch ();
	hfla_cfg_if cfg_ch ();

	handle_free_list_allocator #(
		.MAX_HANDLES (MAX_HANDLES),
		.PAYLOAD_BITS(hfla_pkg::WORD_W)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow handle tables
	logic [hfla_pkg::WORD_W-1:0] tbl_payload [2][MAX_HANDLES];
	bit                          tbl_used    [2][MAX_HANDLES];
	int unsigned                 tbl_link    [2][MAX_HANDLES];
	int unsigned                 tbl_head    [2];
	int unsigned                 tbl_count   [2];
	int unsigned                 tbl_active  [2];

	stim_t          stim_q[$];
	hfla_pkg::rsp_t expected_q[$];

	int          err_cnt = 0;
	int          cfg_writes = 0;
	int          op_seen [4] = '{0, 0, 0, 0};
	int          ok_cnt = 0;
	int          refused_cnt = 0;
	int unsigned peak_used = 0;

	int          req_xfer_cnt;
	int          hold_left;
	bit          hold_armed;

	int          req_gap, req_calm, in_flight;
	int          rsp_stall, rsp_calm;

	function automatic void table_rebuild(int who, logic [hfla_pkg::COUNT_W-1:0] value);
		int unsigned n;
		n = 32'(value);
		if (n < 1)
			n = 1;
		else if (n > MAX_HANDLES)
			n = MAX_HANDLES;
		tbl_active[who] = n;
		for (int i = 0; i < MAX_HANDLES; i++) begin
			tbl_payload[who][i] = '0;
			tbl_used[who][i]    = 1'b0;
			tbl_link[who][i]    = (i + 1 < n) ? i + 2 : 0;
		end
		tbl_head[who]  = 1;
		tbl_count[who] = 0;
	endfunction

	function automatic logic [hfla_pkg::WORD_W-1:0] table_release(int who, int unsigned h);
		logic [hfla_pkg::WORD_W-1:0] p;
		p = tbl_payload[who][h];
		tbl_payload[who][h] = '0;
		tbl_used[who][h]    = 1'b0;
		tbl_link[who][h]    = tbl_head[who];
		tbl_head[who]       = h + 1;
		tbl_count[who]--;
		return p;
	endfunction

	function automatic hfla_pkg::rsp_t table_apply(int who, hfla_pkg::req_t r);
		hfla_pkg::rsp_t res;
		int unsigned    g;
		bit             found;
		res   = '0;
		found = 1'b0;
		case (r.op)
			hfla_pkg::OP_ALLOC: begin
				if (tbl_head[who] != 0 && tbl_head[who] <= tbl_active[who]) begin
					g = tbl_head[who] - 1;
					tbl_head[who]       = tbl_link[who][g];
					tbl_link[who][g]    = 0;
					tbl_used[who][g]    = 1'b1;
					tbl_payload[who][g] = r.payload_in;
					tbl_count[who]++;
					res.ok         = 1'b1;
					res.handle_out = hfla_pkg::HANDLE_W'(g);
				end
			end
			hfla_pkg::OP_FREE: begin
				if (r.handle_in < tbl_active[who] && tbl_used[who][r.handle_in]) begin
					res.payload_out = table_release(who, 32'(r.handle_in));
					res.ok          = 1'b1;
					res.handle_out  = r.handle_in;
				end
			end
			hfla_pkg::OP_RELEASE_LOWEST: begin
				if (tbl_count[who] != 0) begin
					for (int i = 0; i < tbl_active[who]; i++) begin
						if (!found && tbl_used[who][i]) begin
							found           = 1'b1;
							res.payload_out = table_release(who, i);
							res.ok          = 1'b1;
							res.handle_out  = hfla_pkg::HANDLE_W'(i);
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.used_count = hfla_pkg::COUNT_W'(tbl_count[who]);
		return res;
	endfunction

	task automatic push_req(logic [hfla_pkg::OP_W-1:0] op,
			logic [hfla_pkg::WORD_W-1:0] payload, logic [hfla_pkg::HANDLE_W-1:0] handle);
		stim_t s;
		s.is_cfg         = 1'b0;
		s.count          = '0;
		s.req.op         = op;
		s.req.payload_in = payload;
		s.req.handle_in  = handle;
		void'(table_apply(GEN, s.req));
		stim_q.push_back(s);
	endtask

	task automatic push_cfg(logic [hfla_pkg::COUNT_W-1:0] value);
		stim_t s;
		s        = '0;
		s.is_cfg = 1'b1;
		s.count  = value;
		table_rebuild(GEN, value);
		stim_q.push_back(s);
	endtask

	// mostly frees of handles actually held, so the list churns instead of
	// just filling up; the rest is bad frees, scans and unknown ops
	task automatic gen_phase(logic [hfla_pkg::COUNT_W-1:0] value, int items, int alloc_pct);
		int unsigned start, idx;
		int          r;
		bit          hit;
		push_cfg(value);
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(99);
			if (r < alloc_pct) begin
				push_req(hfla_pkg::OP_ALLOC, $urandom(),
					hfla_pkg::HANDLE_W'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				if (r < 55 && tbl_count[GEN] != 0) begin
					start = $urandom_range(tbl_active[GEN] - 1);
					hit   = 1'b0;
					idx   = 0;
					for (int j = 0; j < tbl_active[GEN]; j++) begin
						if (!hit && tbl_used[GEN][(start + j) % tbl_active[GEN]]) begin
							hit = 1'b1;
							idx = (start + j) % tbl_active[GEN];
						end
					end
					push_req(hfla_pkg::OP_FREE, $urandom(), hfla_pkg::HANDLE_W'(idx));
				end else if (r < 72) begin
					push_req(hfla_pkg::OP_FREE, $urandom(),
						hfla_pkg::HANDLE_W'($urandom_range(255)));
				end else if (r < 93) begin
					push_req(hfla_pkg::OP_RELEASE_LOWEST, $urandom(),
						hfla_pkg::HANDLE_W'($urandom_range(255)));
				end else begin
					push_req(OP_UNKNOWN, $urandom(), hfla_pkg::HANDLE_W'($urandom_range(255)));
				end
			end
		end
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (err_cnt < 40)
			$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_cnt++;
	endtask

	// request and count-write driver
	always @(posedge clk or negedge arst_n) begin
		hfla_pkg::rsp_t pred;
		bit             req_busy, cfg_busy, send_req, send_cfg;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.data  <= '0;
			req_xfer_cnt <= 0;
			req_gap   = 0;
			req_calm  = 0;
			in_flight = 0;
		end else begin
			req_busy = req_ch.valid && !req_ch.ready;
			cfg_busy = cfg_ch.valid && !cfg_ch.ready;
			send_req = 1'b0;
			send_cfg = 1'b0;
			if (req_ch.valid && req_ch.ready) begin
				pred = table_apply(CHK, req_ch.data);
				expected_q.push_back(pred);
				in_flight++;
				op_seen[req_ch.data.op]++;
				req_xfer_cnt <= req_xfer_cnt + 1;
				if (req_calm > 0) begin
					req_calm--;
					req_gap = 0;
				end else begin
					req_gap = idle_len();
					if ($urandom_range(99) < 3)
						req_calm = $urandom_range(60, 20);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready)
				in_flight--;
			if (cfg_ch.valid && cfg_ch.ready) begin
				table_rebuild(CHK, cfg_ch.data);
				cfg_writes++;
			end
			if (!req_busy && !cfg_busy) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (stim_q.size() > 0) begin
					// count writes only go out once every response is back
					if (!stim_q[0].is_cfg)
						send_req = 1'b1;
					else if (in_flight == 0)
						send_cfg = 1'b1;
				end
				if (send_req)
					req_ch.data <= stim_q[0].req;
				if (send_cfg)
					cfg_ch.data <= stim_q[0].count;
				if (send_req || send_cfg)
					void'(stim_q.pop_front());
				req_ch.valid <= send_req;
				cfg_ch.valid <= send_cfg;
			end
		end
	end

	// one long response hold-off early in the run, so the input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && req_xfer_cnt == 60) begin
			hold_left  <= 150;
			hold_armed <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		hfla_pkg::rsp_t want;
		bit             go;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall = 0;
			rsp_calm  = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected response, handle_out",
						64'(rsp_ch.data.handle_out), '0);
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.data.ok !== want.ok)
						report_mismatch("ok", 64'(rsp_ch.data.ok), 64'(want.ok));
					if (rsp_ch.data.handle_out !== want.handle_out)
						report_mismatch("handle_out", 64'(rsp_ch.data.handle_out),
							64'(want.handle_out));
					if (rsp_ch.data.payload_out !== want.payload_out)
						report_mismatch("payload_out", 64'(rsp_ch.data.payload_out),
							64'(want.payload_out));
					if (rsp_ch.data.used_count !== want.used_count)
						report_mismatch("used_count", 64'(rsp_ch.data.used_count),
							64'(want.used_count));
					if (want.ok)
						ok_cnt++;
					else
						refused_cnt++;
					if (32'(want.used_count) > peak_used)
						peak_used = 32'(want.used_count);
				end
			end
			if (rsp_calm > 0) begin
				rsp_calm--;
				go = 1'b1;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				go = 1'b0;
			end else begin
				go = 1'b1;
				if ($urandom_range(99) < 30)
					rsp_stall = idle_len();
				if ($urandom_range(99) < 3)
					rsp_calm = $urandom_range(60, 20);
			end
			rsp_ch.ready <= go && (hold_left == 0);
		end
	end

	initial begin
		arst_n = 1'b0;
		table_rebuild(GEN, 9'd256);
		table_rebuild(CHK, 9'd256);

		// full table out of reset: payload extremes, bad frees, empty scan
		push_req(hfla_pkg::OP_ALLOC, 32'hFFFF_FFFF, 8'd0);
		push_req(hfla_pkg::OP_ALLOC, 32'h0000_0000, 8'd0);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd255);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd1);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd0);
		push_req(OP_UNKNOWN, 32'hFFFF_FFFF, 8'd255);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);

		// three handles: run dry, double free, out of range, LIFO reuse
		push_cfg(9'd3);
		push_req(hfla_pkg::OP_ALLOC, 32'hA5A5_A5A5, 8'd0);
		push_req(hfla_pkg::OP_ALLOC, 32'h5A5A_5A5A, 8'd0);
		push_req(hfla_pkg::OP_ALLOC, 32'h1234_5678, 8'd0);
		push_req(hfla_pkg::OP_ALLOC, 32'hFFFF_FFFF, 8'd0);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd1);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd1);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd3);
		push_req(hfla_pkg::OP_FREE, 32'h0, 8'd255);
		push_req(hfla_pkg::OP_ALLOC, 32'hDEAD_BEEF, 8'd0);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);
		push_req(hfla_pkg::OP_RELEASE_LOWEST, 32'h0, 8'd0);
		push_req(OP_UNKNOWN, 32'h0, 8'd0);

		// oversized count with alloc pressure to drain the whole list
		gen_phase(9'd511, 280, 92);
		gen_phase(9'd0, 50, 50);
		gen_phase(9'd256, 150, 50);
		gen_phase(9'd8, 150, 55);
		gen_phase(9'd17, 150, 45);
		gen_phase(hfla_pkg::COUNT_W'($urandom_range(40, 2)), 150, 50);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (stim_q.size() == 0);
		while (expected_q.size() != 0 || req_ch.valid || cfg_ch.valid)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d alloc, %0d free, %0d release-lowest, %0d unknown requests",
			op_seen[hfla_pkg::OP_ALLOC], op_seen[hfla_pkg::OP_FREE],
			op_seen[hfla_pkg::OP_RELEASE_LOWEST], op_seen[OP_UNKNOWN]);
		$display("%0d count writes, %0d granted, %0d refused, peak of %0d handles held",
			cfg_writes, ok_cnt, refused_cnt, peak_used);
		if (err_cnt == 0)
			$display("** handle_free_list_allocator: PASSED **");
		else
			$display("** handle_free_list_allocator: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d responses outstanding", expected_q.size());
		$display("** handle_free_list_allocator: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/hfla_pkg.sv
hw/rtl/hfla_if.sv
hw/rtl/hfla_ram.sv
hw/rtl/hfla_flags.sv
hw/rtl/handle_free_list_allocator.sv
tb/handle_free_list_allocator_tb.sv
